### hdl/iq_and_audio_fir_filter_assert.svh
// Assertion macros for the filter top level.
`ifndef IQ_AND_AUDIO_FIR_FILTER_ASSERT_SVH
`define IQ_AND_AUDIO_FIR_FILTER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, disabled while reset is low.
`define IQAF_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("iqaf assertion failed");
// Next-cycle implication, disabled while reset is low.
`define IQAF_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("iqaf assertion failed");
`else
`define IQAF_ASSERT_NOW(lbl, pre, post)
`define IQAF_ASSERT_NEXT(lbl, pre, post)
`endif
`endif

### hdl/iqaf_pkg.sv
`timescale 1ns / 1ps
package iqaf_pkg;

  // Width of the action selector carried in tuser.
  localparam int unsigned ACT_W = 2;

  // Item kinds. The fourth code is accepted and ignored.
  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_IQ    = 2'd1,
    ACT_AUDIO = 2'd2
  } action_e;

  // Controls from the sequencer to the multiply-accumulate datapath.
  typedef struct packed {
    logic clear;   // Zero both accumulators at the start of a sample.
    logic mul_en;  // Read data is valid: register the products.
    logic acc_en;  // Products are valid: add them into the sums.
    logic audio;   // Use the audio lane instead of the I lane.
  } mac_ctrl_t;

endpackage

### hdl/iqaf_coef_mem.sv
`timescale 1ns / 1ps
module iqaf_coef_mem #(
  parameter int unsigned NUM_TAPS   = 31,
  parameter int unsigned COEFF_BITS = 16,
  parameter int unsigned IDX_W      = 5
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         we_i,
  input  logic [IDX_W-1:0]             waddr_i,
  input  logic signed [COEFF_BITS-1:0] wdata_i,
  input  logic [IDX_W-1:0]             raddr_i,
  output logic signed [COEFF_BITS-1:0] rdata_o
);

  logic signed [COEFF_BITS-1:0] mem_q [NUM_TAPS];
  logic [NUM_TAPS-1:0]          vld_q;
  logic signed [COEFF_BITS-1:0] rdata_q;

  // Coefficient array with a registered read port; unwritten slots read as zero.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= vld_q[raddr_i] ? mem_q[raddr_i] : '0;
  end

  // Per-slot valid bits stand in for the all-zero reset contents.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/iqaf_smp_mem.sv
`timescale 1ns / 1ps
module iqaf_smp_mem #(
  parameter int unsigned NUM_TAPS    = 31,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned IDX_W       = 5
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          we_iq_i,
  input  logic                          we_au_i,
  input  logic [IDX_W-1:0]              waddr_i,
  input  logic signed [SAMPLE_BITS-1:0] wdata_i_i,
  input  logic signed [SAMPLE_BITS-1:0] wdata_q_i,
  input  logic [IDX_W-1:0]              raddr_i,
  output logic signed [SAMPLE_BITS-1:0] rdata_i_o,
  output logic signed [SAMPLE_BITS-1:0] rdata_q_o,
  output logic signed [SAMPLE_BITS-1:0] rdata_a_o
);

  localparam int unsigned SB = SAMPLE_BITS;

  // One word per slot: I lane low, Q lane middle, audio lane high.
  logic [3*SB-1:0]      mem_q [NUM_TAPS];
  logic [NUM_TAPS-1:0]  iq_vld_q;
  logic [NUM_TAPS-1:0]  au_vld_q;
  logic signed [SB-1:0] rd_i_q;
  logic signed [SB-1:0] rd_q_q;
  logic signed [SB-1:0] rd_a_q;

  // Lane writes and a registered read of all three lanes.
  always_ff @(posedge clk_i) begin
    if (we_iq_i) begin
      mem_q[waddr_i][SB-1:0]    <= wdata_i_i;
      mem_q[waddr_i][2*SB-1:SB] <= wdata_q_i;
    end
    if (we_au_i) begin
      mem_q[waddr_i][3*SB-1:2*SB] <= wdata_i_i;
    end
    rd_i_q <= iq_vld_q[raddr_i] ? $signed(mem_q[raddr_i][SB-1:0]) : '0;
    rd_q_q <= iq_vld_q[raddr_i] ? $signed(mem_q[raddr_i][2*SB-1:SB]) : '0;
    rd_a_q <= au_vld_q[raddr_i] ? $signed(mem_q[raddr_i][3*SB-1:2*SB]) : '0;
  end

  // Valid bits per lane group; a slot never written reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iq_vld_q <= '0;
      au_vld_q <= '0;
    end else begin
      if (we_iq_i) begin
        iq_vld_q[waddr_i] <= 1'b1;
      end
      if (we_au_i) begin
        au_vld_q[waddr_i] <= 1'b1;
      end
    end
  end

  assign rdata_i_o = rd_i_q;
  assign rdata_q_o = rd_q_q;
  assign rdata_a_o = rd_a_q;

endmodule

### hdl/iqaf_mac.sv
`timescale 1ns / 1ps
module iqaf_mac #(
  parameter int unsigned NUM_TAPS    = 31,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEFF_BITS  = 16
) (
  input  logic                          clk_i,
  input  iqaf_pkg::mac_ctrl_t           ctrl_i,
  input  logic signed [COEFF_BITS-1:0]  coef_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_i_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_q_i,
  input  logic signed [SAMPLE_BITS-1:0] smp_a_i,
  output logic signed [SAMPLE_BITS-1:0] res_i_o,
  output logic signed [SAMPLE_BITS-1:0] res_q_o
);

  localparam int unsigned MUL_W = SAMPLE_BITS + COEFF_BITS;
  localparam int unsigned ACC_W = MUL_W + $clog2(NUM_TAPS + 1);
  localparam int unsigned SHIFT = COEFF_BITS - 1;
  localparam logic signed [ACC_W-1:0] HALF    = ACC_W'(2 ** (COEFF_BITS - 2));
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(2 ** (SAMPLE_BITS - 1) - 1);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -SAT_MAX - ACC_W'(1);

  logic signed [SAMPLE_BITS-1:0] smp_sel;
  logic signed [MUL_W-1:0]       prod_i_d, prod_i_q;
  logic signed [MUL_W-1:0]       prod_q_d, prod_q_q;
  logic signed [ACC_W-1:0]       acc_i_q, acc_q_q;

  // The in-phase multiplier also serves the audio lane.
  assign smp_sel  = ctrl_i.audio ? smp_a_i : smp_i_i;
  assign prod_i_d = coef_i * smp_sel;
  assign prod_q_d = coef_i * smp_q_i;

  // Product register, then the accumulators.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_i_q <= prod_i_d;
      prod_q_q <= prod_q_d;
    end
    if (ctrl_i.clear) begin
      acc_i_q <= '0;
      acc_q_q <= '0;
    end else if (ctrl_i.acc_en) begin
      acc_i_q <= acc_i_q + ACC_W'(prod_i_q);
      acc_q_q <= acc_q_q + ACC_W'(prod_q_q);
    end
  end

  // Round half up to the sample scale, then saturate.
  function automatic logic signed [SAMPLE_BITS-1:0] round_sat(logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] sh;
    sh = (acc + HALF) >>> SHIFT;
    if (sh > SAT_MAX) begin
      return SAT_MAX[SAMPLE_BITS-1:0];
    end else if (sh < SAT_MIN) begin
      return SAT_MIN[SAMPLE_BITS-1:0];
    end
    return sh[SAMPLE_BITS-1:0];
  endfunction

  assign res_i_o = round_sat(acc_i_q);
  assign res_q_o = round_sat(acc_q_q);

endmodule

### hdl/iq_and_audio_fir_filter.sv
`timescale 1ns / 1ps
// Sample request: one coefficient and one delay-line read per tap pass through a three-stage
// pipe (read, product, accumulate); the sums are then rounded and saturated into the output
// register, and the next request is taken the cycle after that result enters the register.
// A full output register holds the sequencer until it drains. A coefficient load or an unused
// action gives no result and leaves the input ready. Reset (asynchronous, active low) clears the
// control and all valid bits at once, so every slot reads as zero; no clearing pass is needed.
`include "iq_and_audio_fir_filter_assert.svh"
module iq_and_audio_fir_filter #(
  parameter int unsigned NUM_TAPS    = 31,
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COEFF_BITS  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid_i,
  output logic s_axis_tready_o,
  // Fields from bit 0: tap_index, coeff_value, sample_i, sample_q, zero fill.
  input  logic [(((NUM_TAPS > 1 ? $clog2(NUM_TAPS) : 1) + COEFF_BITS + 2 * SAMPLE_BITS + 7)
                / 8) * 8 - 1:0] s_axis_tdata_i,
  // Fields from bit 0: action.
  input  logic [iqaf_pkg::ACT_W-1:0] s_axis_tuser_i,
  output logic m_axis_tvalid_o,
  input  logic m_axis_tready_i,
  // Fields from bit 0: result_i, result_q, zero fill.
  output logic [((2 * SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_axis_tdata_o,
  // Fields from bit 0: is_audio.
  output logic m_axis_tuser_o
);

  localparam int unsigned IDX_W  = NUM_TAPS > 1 ? $clog2(NUM_TAPS) : 1;
  localparam int unsigned CNT_W  = $clog2(NUM_TAPS + 1);
  localparam int unsigned SB     = SAMPLE_BITS;
  localparam int unsigned CB     = COEFF_BITS;
  localparam int unsigned OUT_TW = ((2 * SB + 7) / 8) * 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ROUND
  } state_e;

  state_e              state_d, state_q;
  logic [IDX_W-1:0]    wp_d, wp_q;
  logic [CNT_W-1:0]    iss_cnt_d, iss_cnt_q;
  logic [IDX_W-1:0]    rd_idx_d, rd_idx_q;
  logic                rd_vld_d, rd_vld_q;
  logic                rd_last_d, rd_last_q;
  logic                pr_vld_d, pr_vld_q;
  logic                pr_last_d, pr_last_q;
  logic                audio_d, audio_q;
  logic                m_valid_d, m_valid_q;
  logic [OUT_TW-1:0]   m_data_d, m_data_q;
  logic                m_user_d, m_user_q;

  logic                in_acc;
  logic                issue;
  logic [IDX_W-1:0]    tap_index;
  logic signed [CB-1:0] coeff_value;
  logic signed [SB-1:0] sample_i;
  logic signed [SB-1:0] sample_q;
  logic                coef_we;
  logic                we_iq;
  logic                we_au;
  logic signed [CB-1:0] coef_rd;
  logic signed [SB-1:0] smp_i_rd, smp_q_rd, smp_a_rd;
  logic signed [SB-1:0] res_i, res_q;
  iqaf_pkg::mac_ctrl_t  mac_ctrl;

  // Unpack the request.
  assign tap_index   = s_axis_tdata_i[IDX_W-1:0];
  assign coeff_value = $signed(s_axis_tdata_i[IDX_W +: CB]);
  assign sample_i    = $signed(s_axis_tdata_i[IDX_W + CB +: SB]);
  assign sample_q    = $signed(s_axis_tdata_i[IDX_W + CB + SB +: SB]);

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // Store writes happen in the accept cycle.
  assign coef_we = in_acc && (s_axis_tuser_i == iqaf_pkg::ACT_LOAD)
                   && (int'(tap_index) < NUM_TAPS);
  assign we_iq   = in_acc && (s_axis_tuser_i == iqaf_pkg::ACT_IQ);
  assign we_au   = in_acc && (s_axis_tuser_i == iqaf_pkg::ACT_AUDIO);

  assign issue = (state_q == ST_RUN) && (iss_cnt_q < CNT_W'(NUM_TAPS));

  assign mac_ctrl.clear  = we_iq || we_au;
  assign mac_ctrl.mul_en = rd_vld_q;
  assign mac_ctrl.acc_en = pr_vld_q;
  assign mac_ctrl.audio  = audio_q;

  iqaf_coef_mem #(
    .NUM_TAPS  (NUM_TAPS),
    .COEFF_BITS(COEFF_BITS),
    .IDX_W     (IDX_W)
  ) u_coef_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (coef_we),
    .waddr_i(tap_index),
    .wdata_i(coeff_value),
    .raddr_i(iss_cnt_q[IDX_W-1:0]),
    .rdata_o(coef_rd)
  );

  iqaf_smp_mem #(
    .NUM_TAPS   (NUM_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .IDX_W      (IDX_W)
  ) u_smp_mem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .we_iq_i  (we_iq),
    .we_au_i  (we_au),
    .waddr_i  (wp_q),
    .wdata_i_i(sample_i),
    .wdata_q_i(sample_q),
    .raddr_i  (rd_idx_q),
    .rdata_i_o(smp_i_rd),
    .rdata_q_o(smp_q_rd),
    .rdata_a_o(smp_a_rd)
  );

  iqaf_mac #(
    .NUM_TAPS   (NUM_TAPS),
    .SAMPLE_BITS(SAMPLE_BITS),
    .COEFF_BITS (COEFF_BITS)
  ) u_mac (
    .clk_i  (clk_i),
    .ctrl_i (mac_ctrl),
    .coef_i (coef_rd),
    .smp_i_i(smp_i_rd),
    .smp_q_i(smp_q_rd),
    .smp_a_i(smp_a_rd),
    .res_i_o(res_i),
    .res_q_o(res_q)
  );

  // Sequencer: walk the taps, drain the pipeline, then hand the result over.
  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    iss_cnt_d = iss_cnt_q;
    rd_idx_d  = rd_idx_q;
    audio_d   = audio_q;
    m_valid_d = m_valid_q;
    m_data_d  = m_data_q;
    m_user_d  = m_user_q;
    rd_vld_d  = issue;
    rd_last_d = issue && (iss_cnt_q == CNT_W'(NUM_TAPS - 1));
    pr_vld_d  = rd_vld_q;
    pr_last_d = rd_last_q;

    if (m_valid_q && m_axis_tready_i) begin
      m_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (we_iq || we_au) begin
          state_d   = ST_RUN;
          iss_cnt_d = '0;
          rd_idx_d  = wp_q;
          audio_d   = we_au;
        end
      end
      ST_RUN: begin
        if (issue) begin
          iss_cnt_d = iss_cnt_q + CNT_W'(1);
          rd_idx_d  = (rd_idx_q == '0) ? IDX_W'(NUM_TAPS - 1) : rd_idx_q - IDX_W'(1);
        end
        if (pr_last_q) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (!m_valid_q || m_axis_tready_i) begin
          m_valid_d            = 1'b1;
          m_data_d             = '0;
          m_data_d[SB-1:0]     = res_i;
          m_data_d[SB +: SB]   = audio_q ? '0 : res_q;
          m_user_d             = audio_q;
          wp_d                 = (wp_q == IDX_W'(NUM_TAPS - 1)) ? '0 : wp_q + IDX_W'(1);
          state_d              = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      iss_cnt_q <= '0;
      rd_idx_q  <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
      pr_vld_q  <= 1'b0;
      pr_last_q <= 1'b0;
      audio_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
      m_user_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      iss_cnt_q <= iss_cnt_d;
      rd_idx_q  <= rd_idx_d;
      rd_vld_q  <= rd_vld_d;
      rd_last_q <= rd_last_d;
      pr_vld_q  <= pr_vld_d;
      pr_last_q <= pr_last_d;
      audio_q   <= audio_d;
      m_valid_q <= m_valid_d;
      m_data_q  <= m_data_d;
      m_user_q  <= m_user_d;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;

  // The write pointer stays inside the delay line.
  `IQAF_ASSERT_NOW(a_wp_range, 1'b1, int'(wp_q) < NUM_TAPS)
  // The tap counter never exceeds NUM_TAPS.
  `IQAF_ASSERT_NOW(a_cnt_range, 1'b1, iss_cnt_q <= CNT_W'(NUM_TAPS))
  // The pointer only moves when a result is handed to the output register.
  `IQAF_ASSERT_NEXT(a_wp_hold, state_q != ST_ROUND, $stable(wp_q))
  // A finished result with room in the output register shows up the next cycle.
  `IQAF_ASSERT_NEXT(a_out_load, (state_q == ST_ROUND) && (!m_valid_q || m_axis_tready_i),
                    m_valid_q && (state_q == ST_IDLE))

endmodule

### bench/tb.sv
`timescale 1ns / 1ps
module tb;

  localparam int NUM_TAPS     = 31;
  localparam int TAP_W        = 5;
  localparam int SAMPLE_W     = 16;
  localparam int COEFF_W      = 16;
  localparam int IN_W         = ((TAP_W + COEFF_W + 2 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_W        = ((2 * SAMPLE_W + 7) / 8) * 8;
  localparam logic [iqaf_pkg::ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Delay-line lanes of the filter state.
  localparam int LANE_I       = 0;
  localparam int LANE_Q       = 1;
  localparam int LANE_AUDIO   = 2;

  localparam longint SAT_MAX  = (longint'(1) <<< (SAMPLE_W - 1)) - 1;
  localparam longint SAT_MIN  = -(longint'(1) <<< (SAMPLE_W - 1));

  // Random mix and flow-control shaping.
  localparam int WORK_ITEMS   = 850;
  localparam int IDLE_PCT     = 34;
  localparam int TX_QUIET_LO  = 480;
  localparam int TX_QUIET_HI  = 640;
  localparam int RX_QUIET_LO  = 120;
  localparam int RX_QUIET_HI  = 220;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 80;

  typedef struct packed {
    logic                            pause;  // Wait until every result is back.
    logic [iqaf_pkg::ACT_W-1:0]      act;
    logic [TAP_W-1:0]                tap;
    logic signed [COEFF_W-1:0]       coeff;
    logic signed [SAMPLE_W-1:0]      samp_i;
    logic signed [SAMPLE_W-1:0]      samp_q;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] res_i;
    logic signed [SAMPLE_W-1:0] res_q;
    logic                       audio;
  } filtered_t;

  logic                       clk_i           = 1'b0;
  logic                       rst_ni          = 1'b0;
  logic                       s_axis_tvalid_i = 1'b0;
  logic                       s_axis_tready_o;
  // Fields from bit 0: tap_index, coeff_value, sample_i, sample_q, zero fill.
  logic [IN_W-1:0]            s_axis_tdata_i  = '0;
  // Fields from bit 0: action.
  logic [iqaf_pkg::ACT_W-1:0] s_axis_tuser_i  = iqaf_pkg::ACT_LOAD;
  logic                       m_axis_tvalid_o;
  logic                       m_axis_tready_i = 1'b0;
  // Fields from bit 0: result_i, result_q, zero fill.
  logic [OUT_W-1:0]           m_axis_tdata_o;
  // Fields from bit 0: is_audio.
  logic                       m_axis_tuser_o;

  iq_and_audio_fir_filter #(
    .NUM_TAPS   (NUM_TAPS),
    .SAMPLE_BITS(SAMPLE_W),
    .COEFF_BITS (COEFF_W)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  // Filter state mirrored on the bench side.
  logic signed [COEFF_W-1:0]  coeffs [NUM_TAPS];
  logic signed [SAMPLE_W-1:0] delay_line [3][NUM_TAPS];
  int                         wr_ptr;

  sample_item_t items_to_send[$];
  filtered_t    filtered_q[$];
  sample_item_t offered;

  int n_sent, n_predicted, n_checked, n_queued_work, errors;
  int n_iq, n_audio, n_load, n_ignored;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sum of products over all taps for one lane, rounded half up and saturated.
  function automatic logic signed [SAMPLE_W-1:0] fir_output(input int lane);
    longint acc;
    longint rounded;
    int     idx;
    acc = 0;
    idx = wr_ptr;
    for (int t = 0; t < NUM_TAPS; t++) begin
      acc += longint'(delay_line[lane][idx]) * longint'(coeffs[t]);
      idx = (idx == 0) ? NUM_TAPS - 1 : idx - 1;
    end
    rounded = (acc + (longint'(1) <<< (COEFF_W - 2))) >>> (COEFF_W - 1);
    if (rounded > SAT_MAX) rounded = SAT_MAX;
    if (rounded < SAT_MIN) rounded = SAT_MIN;
    return rounded[SAMPLE_W-1:0];
  endfunction

  // Update the mirrored state with one accepted request and queue the result of a sample.
  task automatic apply_item(input sample_item_t it);
    filtered_t res;
    if (it.act == iqaf_pkg::ACT_LOAD) begin
      if (it.tap < NUM_TAPS) begin
        coeffs[it.tap] = it.coeff;
        n_load++;
      end else begin
        n_ignored++;
      end
    end else if (it.act == iqaf_pkg::ACT_IQ || it.act == iqaf_pkg::ACT_AUDIO) begin
      if (it.act == iqaf_pkg::ACT_IQ) begin
        delay_line[LANE_I][wr_ptr] = it.samp_i;
        delay_line[LANE_Q][wr_ptr] = it.samp_q;
        res.res_i = fir_output(LANE_I);
        res.res_q = fir_output(LANE_Q);
        res.audio = 1'b0;
        n_iq++;
      end else begin
        delay_line[LANE_AUDIO][wr_ptr] = it.samp_i;
        res.res_i = fir_output(LANE_AUDIO);
        res.res_q = '0;
        res.audio = 1'b1;
        n_audio++;
      end
      filtered_q = {filtered_q, res};
      n_predicted++;
      wr_ptr = (wr_ptr == NUM_TAPS - 1) ? 0 : wr_ptr + 1;
    end else begin
      n_ignored++;
    end
    n_sent++;
  endtask

  task automatic add_raw(input logic [iqaf_pkg::ACT_W-1:0] act, input int tap,
                         input logic [15:0] coeff, input logic [15:0] si,
                         input logic [15:0] sq);
    sample_item_t it;
    it.pause  = 1'b0;
    it.act    = act;
    it.tap    = tap[TAP_W-1:0];
    it.coeff  = coeff;
    it.samp_i = si;
    it.samp_q = sq;
    items_to_send = {items_to_send, it};
    if (act == iqaf_pkg::ACT_IQ || act == iqaf_pkg::ACT_AUDIO ||
        (act == iqaf_pkg::ACT_LOAD && tap < NUM_TAPS))
      n_queued_work++;
  endtask

  task automatic add_load(input int tap, input logic [15:0] coeff);
    add_raw(iqaf_pkg::ACT_LOAD, tap, coeff, 16'($urandom), 16'($urandom));
  endtask

  task automatic add_iq(input logic [15:0] si, input logic [15:0] sq);
    add_raw(iqaf_pkg::ACT_IQ, $urandom_range(0, NUM_TAPS), 16'($urandom), si, sq);
  endtask

  task automatic add_audio(input logic [15:0] a);
    add_raw(iqaf_pkg::ACT_AUDIO, $urandom_range(0, NUM_TAPS), 16'($urandom), a,
            16'($urandom));
  endtask

  task automatic add_pause();
    sample_item_t it;
    it       = '0;
    it.pause = 1'b1;
    items_to_send = {items_to_send, it};
  endtask

  // Mostly moderate coefficients so outputs vary, with the extremes mixed in.
  function automatic logic [15:0] rand_coeff();
    logic signed [15:0] v;
    v = 16'($urandom);
    case ($urandom_range(0, 7))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      default: return v >>> $urandom_range(1, 6);
    endcase
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Request driver: presents queued items and honors pause markers.
  always @(posedge clk_i or negedge rst_ni) begin : req_driver
    logic gap;
    if (!rst_ni) begin
      s_axis_tvalid_i <= 1'b0;
      s_axis_tdata_i  <= '0;
      s_axis_tuser_i  <= iqaf_pkg::ACT_LOAD;
    end else begin
      if (s_axis_tvalid_i && s_axis_tready_o) apply_item(offered);
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (items_to_send.size() > 0 && items_to_send[0].pause && n_checked == n_predicted)
          void'(items_to_send.pop_front());
        gap = (n_sent < TX_QUIET_LO || n_sent >= TX_QUIET_HI) &&
              ($urandom_range(0, 99) < IDLE_PCT);
        if (items_to_send.size() > 0 && !items_to_send[0].pause && !gap) begin
          offered = items_to_send.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tdata_i  <= {offered.samp_q, offered.samp_i, offered.coeff, offered.tap};
          s_axis_tuser_i  <= offered.act;
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Result ready: random stalls, a quiet stretch, and one long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin : rsp_ready
    int  hold_left;
    logic hold_done;
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (hold_left > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_left--;
    end else if (!hold_done && n_checked >= HOLD_AT) begin
      m_axis_tready_i <= 1'b0;
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end else if (n_checked >= RX_QUIET_LO && n_checked < RX_QUIET_HI) begin
      m_axis_tready_i <= 1'b1;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  // Compare each returned result with the oldest expected one.
  always @(posedge clk_i) begin : result_check
    filtered_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (filtered_q.size() == 0) begin
        $error("unexpected result: result_i %0d, result_q %0d, is_audio %0d",
               $signed(m_axis_tdata_o[15:0]), $signed(m_axis_tdata_o[31:16]),
               m_axis_tuser_o);
        errors++;
      end else begin
        want = filtered_q.pop_front();
        if (m_axis_tdata_o[15:0] !== want.res_i) begin
          $error("result_i mismatch: expected %0d, got %0d", want.res_i,
                 $signed(m_axis_tdata_o[15:0]));
          errors++;
        end
        if (m_axis_tdata_o[31:16] !== want.res_q) begin
          $error("result_q mismatch: expected %0d, got %0d", want.res_q,
                 $signed(m_axis_tdata_o[31:16]));
          errors++;
        end
        if (m_axis_tuser_o !== want.audio) begin
          $error("is_audio mismatch: expected %0d, got %0d", want.audio, m_axis_tuser_o);
          errors++;
        end
      end
      n_checked <= n_checked + 1;
    end
  end

  initial begin : run_limit
    #5_000_000;
    $display("timeout: %0d of %0d results seen", n_checked, n_predicted);
    $display("** iq_and_audio_fir_filter: FAILED **");
    $finish;
  end

  initial begin : stimulus
    int  nload, burst;
    logic mid_pause_done;
    for (int t = 0; t < NUM_TAPS; t++) begin
      coeffs[t] = '0;
      delay_line[LANE_I][t] = '0;
      delay_line[LANE_Q][t] = '0;
      delay_line[LANE_AUDIO][t] = '0;
    end
    wr_ptr = 0;
    mid_pause_done = 1'b0;

    // Directed: zero taps after reset, field extremes, saturation and rounding.
    add_iq(16'sd100, -16'sd100);
    add_load(0, 16'sh8000);
    add_load(1, 16'sh8000);
    add_load(NUM_TAPS - 1, 16'sh7fff);
    add_load(NUM_TAPS, 16'sh3039);   // slot past the last tap: dropped
    add_raw(ACT_UNUSED, 31, 16'hffff, 16'hffff, 16'hffff);
    add_iq(16'sh8000, 16'sh7fff);
    add_iq(16'sh8000, 16'sh8000);
    add_audio(16'sh8000);
    add_audio(16'sh8000);
    add_audio(16'sh7fff);
    add_audio(16'sh7fff);
    add_load(0, 16'sh4000);
    add_load(1, 16'sh0000);
    add_load(NUM_TAPS - 1, 16'sh0000);
    add_audio(16'sd1);               // half rounds up
    add_audio(-16'sd1);              // minus half rounds up to zero
    add_iq(16'sd3, -16'sd3);
    add_iq(16'sh7fff, 16'sh8000);
    add_pause();

    // Random: coefficient reloads followed by sample bursts, plus noise.
    while (n_queued_work < WORK_ITEMS) begin
      if ($urandom_range(0, 99) < 75) begin
        nload = ($urandom_range(0, 3) == 0) ? NUM_TAPS : $urandom_range(0, 6);
        for (int k = 0; k < nload; k++)
          add_load((nload == NUM_TAPS) ? k : $urandom_range(0, NUM_TAPS - 1), rand_coeff());
        burst = $urandom_range(5, 40);
        for (int k = 0; k < burst; k++) begin
          if ($urandom_range(0, 1)) add_iq(rand_sample(), rand_sample());
          else add_audio(rand_sample());
        end
      end else begin
        burst = $urandom_range(1, 6);
        for (int k = 0; k < burst; k++)
          add_raw(2'($urandom_range(0, 3)), $urandom_range(0, 31), 16'($urandom),
                  16'($urandom), 16'($urandom));
      end
      if (!mid_pause_done && n_queued_work >= WORK_ITEMS / 2) begin
        add_pause();
        mid_pause_done = 1'b1;
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every request sent and every expected result returned.
    while (items_to_send.size() != 0 || s_axis_tvalid_i || n_checked < n_predicted)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (filtered_q.size() != 0) begin
      $error("%0d expected results never arrived", filtered_q.size());
      errors++;
    end

    $display("Covered %0d IQ and %0d audio samples, %0d coefficient loads, %0d ignored requests.",
             n_iq, n_audio, n_load, n_ignored);
    $display("Checked %0d filtered results under random stalls and one long output hold-off.",
             n_checked);
    if (errors == 0) begin
      $display("** iq_and_audio_fir_filter: PASSED **");
    end else begin
      $display("** iq_and_audio_fir_filter: FAILED **");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/iqaf_pkg.sv
hdl/iqaf_coef_mem.sv
hdl/iqaf_smp_mem.sv
hdl/iqaf_mac.sv
hdl/iq_and_audio_fir_filter.sv
bench/tb.sv
